@@ rtl/rtt_pkg.sv @@
// ============================================================================
// Raster to tiled RGBA8 package
// Shared constants, register codes and pixel/tile types of the tiling block.
// ============================================================================
package rtt_pkg;

   // Field widths of the pixel and result words.
   localparam int COMP_W      = 8;
   localparam int WORD_W      = 64;

   // Configuration registers.
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int WIDTH_REG_W   = 11;
   localparam int HEIGHT_REG_W  = 13;
   localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

   // Register index codes, taken from paddr bit 2.
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   // Geometry.
   localparam int MAX_WIDTH_DEFAULT = 1024;
   localparam int ROW_W             = 12;
   localparam logic [1:0] LANE_LAST = 2'd3;
   localparam logic [1:0] ROW_FIRST = 2'd0;
   localparam logic [COMP_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } rgb_type;

   // Four horizontally adjacent pixels of one tile row, lane 0 leftmost.
   typedef rgb_type [3:0] quad_type;

   // A complete tile as handed to the output side.
   typedef struct packed {
      quad_type [3:0] rows;
      logic [1:0]     cur_row;
      logic [1:0]     last_lane;
      logic           last_image;
   } tile_type;

endpackage

@@ rtl/rtt_ifs.sv @@
// ============================================================================
// Raster to tiled RGBA8 channel interfaces
// Valid/ready channels for incoming pixels and outgoing tile words.
// ============================================================================
interface rtt_pixel_if;
   logic                       valid;
   logic                       ready;
   logic [rtt_pkg::COMP_W-1:0] red;
   logic [rtt_pkg::COMP_W-1:0] green;
   logic [rtt_pkg::COMP_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rtt_word_if;
   logic                       valid;
   logic                       ready;
   logic [rtt_pkg::WORD_W-1:0] tile_word;
   logic                       last_of_tile;
   logic                       last_of_image;

   modport source (output valid, output tile_word, output last_of_tile,
                   output last_of_image, input ready);
   modport sink   (input valid, input tile_word, input last_of_tile,
                   input last_of_image, output ready);
endinterface

@@ rtl/raster_rgb_to_tiled_rgba8.sv @@
// ============================================================================
// Raster RGB to tiled RGBA8 converter
// Collects raster pixels in a four-row line store and emits 4x4 RGBA8 tiles.
// ============================================================================
// The first word of a tile becomes valid once the gather sequencer has read every earlier
// tile row from the line store and the tile has moved through the tile buffer into the
// output register. Throughput: one pixel per cycle while input is not held; in a band's
// last row four pixels yield eight words, so the 64-bit result port sets the pace, and the
// line store read port holds input off while a tile's upper rows are fetched.
// Reset is synchronous: counters and handshake state clear, the registers return to width
// 640 and height 480; the line store is not cleared and needs no clearing pass.
module raster_rgb_to_tiled_rgba8 #(
   parameter int MAX_WIDTH = rtt_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   rtt_pixel_if.sink                          req_if,
   rtt_word_if.source                         rsp_if,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [rtt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rtt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rtt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   // Column counter width, group count and line store geometry. The store keeps one
   // entry per tile row and column group; each entry holds four pixels in lanes.
   localparam int CW        = $clog2(MAX_WIDTH);
   localparam int CP_W      = CW + 1;
   localparam int NG        = (MAX_WIDTH + 3) / 4;
   localparam int GW        = (NG > 1) ? $clog2(NG) : 1;
   localparam int AW        = GW + 2;
   localparam int MEM_DEPTH = 1 << AW;
   localparam int CMP_W     = (CP_W > rtt_pkg::WIDTH_REG_W) ? CP_W : rtt_pkg::WIDTH_REG_W;

   // The fill sequencer gathers a finished tile: the current row comes from a
   // forwarding register, the rows above it are read from the line store one a cycle.
   typedef enum logic [2:0] {
      FILL_IDLE = 3'b001,
      FILL_READ = 3'b010,
      FILL_FULL = 3'b100
   } fill_state_type;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [rtt_pkg::WIDTH_REG_W-1:0]  width_ff;
   logic [rtt_pkg::HEIGHT_REG_W-1:0] height_ff;
   logic                             csr_write;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rtt_pkg::WIDTH_RESET;
         height_ff <= rtt_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            rtt_pkg::CSR_IDX_WIDTH: begin
               width_ff <= csr_pwdata[rtt_pkg::WIDTH_REG_W-1:0];
            end
            rtt_pkg::CSR_IDX_HEIGHT: begin
               height_ff <= csr_pwdata[rtt_pkg::HEIGHT_REG_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         rtt_pkg::CSR_IDX_WIDTH: begin
            csr_prdata = rtt_pkg::CSR_DATA_W'(width_ff);
         end
         rtt_pkg::CSR_IDX_HEIGHT: begin
            csr_prdata = rtt_pkg::CSR_DATA_W'(height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // Raster position
   // ---------------------------------------------------------------------------
   logic [CW-1:0]                    col_ff, col_in;
   logic [rtt_pkg::ROW_W-1:0]        row_ff, row_in;
   logic [CP_W-1:0]                  col_p1;
   logic [rtt_pkg::HEIGHT_REG_W-1:0] row_p1;
   logic                             row_end;
   logic                             image_end;
   logic                             trigger;
   logic                             accept;
   logic                             trig_acc;
   logic [1:0]                       lane;
   logic [GW-1:0]                    grp;

   assign col_p1 = {1'b0, col_ff} + CP_W'(1);
   assign row_p1 = {1'b0, row_ff} + rtt_pkg::HEIGHT_REG_W'(1);

   // A zero width acts as one pixel; the row also ends at the line store's capacity.
   // A zero height acts as one row; the image also ends at the row counter's limit.
   assign row_end   = (width_ff == '0) ||
                      (CMP_W'(col_p1) >= CMP_W'(width_ff)) ||
                      (CMP_W'(col_p1) >= CMP_W'(MAX_WIDTH));
   assign image_end = (height_ff == '0) || (row_p1 >= height_ff) || (row_ff == '1);

   // A tile is complete on the last pixel of a column group in the band's last row.
   assign trigger = ((col_ff[1:0] == rtt_pkg::LANE_LAST) || row_end) &&
                    ((row_ff[1:0] == rtt_pkg::LANE_LAST) || image_end);

   assign lane = col_ff[1:0];
   assign grp  = GW'(col_ff >> 2);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = image_end ? '0 : row_p1[rtt_pkg::ROW_W-1:0];
         end else begin
            col_in = col_p1[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Line store and current-row forwarding
   // ---------------------------------------------------------------------------
   rtt_pkg::quad_type line_store [MEM_DEPTH];
   rtt_pkg::quad_type cur_grp_ff;
   rtt_pkg::quad_type merged;
   rtt_pkg::rgb_type  pix_in;
   logic [AW-1:0]     waddr;
   logic [AW-1:0]     raddr;
   logic              rd_en;

   assign pix_in = {req_if.red, req_if.green, req_if.blue};
   assign waddr  = {row_ff[1:0], grp};

   always_ff @(posedge clock) begin
      if (accept) begin
         line_store[waddr][lane] <= pix_in;
      end
   end

   // The current row's column group, with the arriving pixel merged in, stands in
   // for a line store read that would otherwise race the write of the same entry.
   always_comb begin
      merged       = cur_grp_ff;
      merged[lane] = pix_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_grp_ff <= merged;
      end
   end

   // ---------------------------------------------------------------------------
   // Tile gathering
   // ---------------------------------------------------------------------------
   fill_state_type             fill_state_ff, fill_state_in;
   logic [1:0]                 rcnt_ff, rcnt_in;
   logic [1:0]                 cur_row_ff;
   logic [1:0]                 last_lane_ff;
   logic                       last_image_ff;
   logic [GW-1:0]              grp_ff;
   rtt_pkg::quad_type [3:0]    fill_rows_ff;
   rtt_pkg::tile_type          tile;
   logic                       tile_valid;
   logic                       tile_ready;

   // Input holds while upper rows are read so that no write can overwrite an entry
   // still to be fetched, and a completing pixel waits for a free gather buffer.
   assign req_if.ready = (fill_state_ff != FILL_READ) &&
                         !(trigger && (fill_state_ff != FILL_IDLE));
   assign accept       = req_if.valid && req_if.ready;
   assign trig_acc     = accept && trigger;

   assign raddr = {rcnt_ff, grp_ff};

   always_comb begin
      fill_state_in = fill_state_ff;
      rcnt_in       = rcnt_ff;
      rd_en         = 1'b0;
      unique case (fill_state_ff)
         FILL_IDLE: begin
            if (trig_acc) begin
               rcnt_in       = '0;
               fill_state_in = (row_ff[1:0] == rtt_pkg::ROW_FIRST) ? FILL_FULL : FILL_READ;
            end
         end
         FILL_READ: begin
            rd_en = 1'b1;
            if (rcnt_ff + 2'd1 == cur_row_ff) begin
               fill_state_in = FILL_FULL;
            end else begin
               rcnt_in = rcnt_ff + 2'd1;
            end
         end
         FILL_FULL: begin
            if (tile_ready) begin
               fill_state_in = FILL_IDLE;
            end
         end
         default: begin
            fill_state_in = FILL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_state_ff <= FILL_IDLE;
         rcnt_ff       <= '0;
      end else begin
         fill_state_ff <= fill_state_in;
         rcnt_ff       <= rcnt_in;
      end
   end

   // Read data lands straight in the gather buffer; the completing pixel's row is
   // loaded from the forwarding register when the pixel is accepted.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         fill_rows_ff[rcnt_ff] <= line_store[raddr];
      end else if (trig_acc) begin
         fill_rows_ff[row_ff[1:0]] <= merged;
      end
   end

   always_ff @(posedge clock) begin
      if (trig_acc) begin
         cur_row_ff    <= row_ff[1:0];
         last_lane_ff  <= lane;
         last_image_ff <= row_end && image_end;
         grp_ff        <= grp;
      end
   end

   assign tile_valid = (fill_state_ff == FILL_FULL);
   assign tile = '{rows:       fill_rows_ff,
                   cur_row:    cur_row_ff,
                   last_lane:  last_lane_ff,
                   last_image: last_image_ff};

   rtt_tile_out u_tile_out (
      .clock      (clock),
      .reset      (reset),
      .tile_valid (tile_valid),
      .tile       (tile),
      .tile_ready (tile_ready),
      .rsp_if     (rsp_if)
   );

`ifndef NO_ASSERTIONS
   // A completing pixel always starts a gather.
   a_trigger_starts_fill: assert property (@(posedge clock) disable iff (reset)
      trig_acc |=> (fill_state_ff != FILL_IDLE))
      else $error("completed tile did not start a gather");

   // No line store write may slip in while a tile's upper rows are being read.
   a_no_write_during_read: assert property (@(posedge clock) disable iff (reset)
      (fill_state_ff == FILL_READ) |-> !accept)
      else $error("line store written during tile read");

   // The column counter stays inside the line store.
   a_column_in_range: assert property (@(posedge clock) disable iff (reset)
      accept |=> ({1'b0, col_ff} < CP_W'(MAX_WIDTH)))
      else $error("column counter beyond line store");
`endif

endmodule

@@ rtl/rtt_tile_out.sv @@
// ============================================================================
// Tile word serializer
// Holds one tile and streams it as eight words through an output register.
// ============================================================================
module rtt_tile_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              tile_valid,
   input  rtt_pkg::tile_type tile,
   output logic              tile_ready,
   rtt_word_if.source        rsp_if
);

   rtt_pkg::tile_type           buf_ff;
   logic                        buf_valid_ff, buf_valid_in;
   logic [2:0]                  word_idx_ff, word_idx_in;
   logic                        out_valid_ff, out_valid_in;
   logic [rtt_pkg::WORD_W-1:0]  tile_word_ff, tile_word_in;
   logic                        last_tile_ff;
   logic                        last_image_ff;
   logic                        load_out;
   logic                        last_word;
   logic                        take_tile;
   rtt_pkg::quad_type           row_sel;

   assign load_out   = buf_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign last_word  = (word_idx_ff == 3'd7);
   assign tile_ready = !buf_valid_ff || (load_out && last_word);
   assign take_tile  = tile_valid && tile_ready;
   assign row_sel    = buf_ff.rows[word_idx_ff[1:0]];

   // Words 0 to 3 carry alpha/red pairs, words 4 to 7 green/blue pairs.
   always_comb begin
      rtt_pkg::rgb_type pix;
      tile_word_in = '0;
      for (int l = 0; l < 4; l++) begin
         if ((word_idx_ff[1:0] <= buf_ff.cur_row) && (2'(l) <= buf_ff.last_lane)) begin
            pix = row_sel[l];
         end else begin
            pix = '0;
         end
         if (word_idx_ff[2]) begin
            tile_word_in[63-16*l -: 16] = {pix.green, pix.blue};
         end else begin
            tile_word_in[63-16*l -: 16] = {rtt_pkg::ALPHA_OPAQUE, pix.red};
         end
      end
   end

   always_comb begin
      buf_valid_in = buf_valid_ff;
      word_idx_in  = word_idx_ff;
      if (load_out) begin
         word_idx_in = word_idx_ff + 3'd1;
         if (last_word) begin
            buf_valid_in = 1'b0;
         end
      end
      if (take_tile) begin
         buf_valid_in = 1'b1;
         word_idx_in  = '0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         word_idx_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
         word_idx_ff  <= word_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_tile) begin
         buf_ff <= tile;
      end
      if (load_out) begin
         tile_word_ff  <= tile_word_in;
         last_tile_ff  <= last_word;
         last_image_ff <= last_word && buf_ff.last_image;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.tile_word     = tile_word_ff;
   assign rsp_if.last_of_tile  = last_tile_ff;
   assign rsp_if.last_of_image = last_image_ff;

endmodule

@@ dv/raster_rgb_to_tiled_rgba8_checker.sv @@
// ============================================================================
// Raster to tiled RGBA8 checker
// Watches the pixel, tile word and register ports of the tiling block, keeps
// its own line store and raster position, predicts every tile word and
// compares each one with the word the block sends out.
// ============================================================================
module raster_rgb_to_tiled_rgba8_checker #(
   parameter int MAX_WIDTH = rtt_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   rtt_pixel_if                              pixel_bus,
   rtt_word_if                               word_bus,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rtt_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [rtt_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic [rtt_pkg::CSR_DATA_W-1:0]    csr_prdata,
   input  logic                              csr_pready,
   output int unsigned                       error_count,
   output int unsigned                       pending_words,
   output int unsigned                       pixels_seen,
   output int unsigned                       words_seen
);
   import rtt_pkg::*;

   localparam int unsigned HEIGHT_MAX = 4096;
   localparam int unsigned PRINT_LIMIT = 30;

   typedef struct packed {
      logic [WORD_W-1:0] data;
      logic              tile_end;
      logic              image_end;
   } tile_word_type;

   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_REG_W-1:0] height_reg;
   rgb_type                 line_store [0:4*MAX_WIDTH-1];
   int unsigned             column_pos;
   int unsigned             row_pos;
   tile_word_type           expected_tile_words [$];

   int unsigned failures = 0;
   int unsigned pending_count = 0;
   int unsigned pixel_total = 0;
   int unsigned word_total = 0;

   assign error_count   = failures;
   assign pending_words = pending_count;
   assign pixels_seen   = pixel_total;
   assign words_seen    = word_total;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      failures++;
      if (failures <= PRINT_LIMIT)
         $display("%0t checker: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Stores one raster pixel and, when it closes a 4x4 tile, queues the
   // eight words of that tile: alpha/red rows first, then green/blue rows.
   task automatic place_pixel(input rgb_type px);
      int unsigned   w, h, x0, y0, x, y;
      logic          row_end, image_end;
      logic [63:0]   alpha_red, green_blue;
      logic [63:0]   alpha_red_rows [4];
      logic [63:0]   green_blue_rows [4];
      rgb_type       texel;
      tile_word_type entry;

      w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);
      row_end   = (column_pos + 1 >= w);
      image_end = (row_pos + 1 >= h);

      if (column_pos < MAX_WIDTH)
         line_store[(row_pos % 4) * MAX_WIDTH + column_pos] = px;

      if (((column_pos % 4) == 3 || row_end) && ((row_pos % 4) == 3 || image_end)) begin
         x0 = column_pos & ~32'd3;
         y0 = row_pos & ~32'd3;
         for (int r = 0; r < 4; r++) begin
            alpha_red  = '0;
            green_blue = '0;
            for (int c = 0; c < 4; c++) begin
               x = x0 + c;
               y = y0 + r;
               // Positions not received yet in this band are padded.
               if (x > column_pos || y > row_pos || x >= MAX_WIDTH)
                  texel = '0;
               else
                  texel = line_store[(y % 4) * MAX_WIDTH + x];
               alpha_red  = {alpha_red[47:0], ALPHA_OPAQUE, texel.red};
               green_blue = {green_blue[47:0], texel.green, texel.blue};
            end
            alpha_red_rows[r]  = alpha_red;
            green_blue_rows[r] = green_blue;
         end
         for (int k = 0; k < 8; k++) begin
            entry.data      = (k < 4) ? alpha_red_rows[k] : green_blue_rows[k-4];
            entry.tile_end  = (k == 7);
            entry.image_end = (k == 7) && row_end && image_end;
            expected_tile_words.push_back(entry);
         end
      end

      if (row_end) begin
         column_pos = 0;
         row_pos    = image_end ? 0 : ((row_pos + 1) & 32'hFFF);
      end else begin
         column_pos = column_pos + 1;
      end
   endtask

   always @(posedge clock) begin
      tile_word_type want;

      if (reset) begin
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         column_pos = 0;
         row_pos    = 0;
         expected_tile_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr[2] == CSR_IDX_WIDTH)
                  width_reg = csr_pwdata[WIDTH_REG_W-1:0];
               else
                  height_reg = csr_pwdata[HEIGHT_REG_W-1:0];
            end else if (csr_paddr[2] == CSR_IDX_WIDTH) begin
               if (csr_prdata !== 32'(width_reg))
                  report_mismatch("width register readback", 64'(csr_prdata),
                                  64'(width_reg));
            end else if (csr_prdata !== 32'(height_reg)) begin
               report_mismatch("height register readback", 64'(csr_prdata),
                               64'(height_reg));
            end
         end

         if (pixel_bus.valid && pixel_bus.ready) begin
            place_pixel({pixel_bus.red, pixel_bus.green, pixel_bus.blue});
            pixel_total++;
         end

         if (word_bus.valid && word_bus.ready) begin
            word_total++;
            if (expected_tile_words.size() == 0) begin
               report_mismatch("tile word with no tile pending", word_bus.tile_word, '0);
            end else begin
               want = expected_tile_words.pop_front();
               if (word_bus.tile_word !== want.data)
                  report_mismatch("tile_word", word_bus.tile_word, want.data);
               if (word_bus.last_of_tile !== want.tile_end)
                  report_mismatch("last_of_tile", 64'(word_bus.last_of_tile),
                                  64'(want.tile_end));
               if (word_bus.last_of_image !== want.image_end)
                  report_mismatch("last_of_image", 64'(word_bus.last_of_image),
                                  64'(want.image_end));
            end
         end
      end
      pending_count = expected_tile_words.size();
   end

endmodule

@@ dv/raster_rgb_to_tiled_rgba8_test.sv @@
// ============================================================================
// Raster to tiled RGBA8 testbench
// Streams raster pixels into the tiling block under changing image sizes,
// with bursty input and a stalling output, while a separate checker predicts
// every tile word; the top only makes stimulus and gives the verdict.
// ============================================================================
module raster_rgb_to_tiled_rgba8_test;
   import rtt_pkg::*;

   localparam int MAX_WIDTH = MAX_WIDTH_DEFAULT;
   localparam int unsigned HEIGHT_MAX = 4096;

   // Register addresses: register index times four.
   localparam logic [CSR_ADDR_W-1:0] WIDTH_ADDR  = {CSR_IDX_WIDTH, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] HEIGHT_ADDR = {CSR_IDX_HEIGHT, 2'b00};

   // Quiet cycles that settle() waits once no tile words are due, time for the
   // block to take in a pixel that closes no tile.
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 16;
   // Cycles with no word, pixel or register access before the run is given up.
   localparam int IDLE_LIMIT    = 4000;
   localparam int unsigned RANDOM_PIXELS = 150;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   rtt_pixel_if pixel_ch ();
   rtt_word_if  word_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int unsigned error_count;
   int unsigned pending_words;
   int unsigned pixels_seen;
   int unsigned words_seen;

   raster_rgb_to_tiled_rgba8 #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (pixel_ch),
      .rsp_if      (word_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   raster_rgb_to_tiled_rgba8_checker #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .pixel_bus     (pixel_ch),
      .word_bus      (word_ch),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .error_count   (error_count),
      .pending_words (pending_words),
      .pixels_seen   (pixels_seen),
      .words_seen    (words_seen)
   );

   // Effective image size as the block sees it after clamping, used to know
   // how many pixels make up a complete image.
   int unsigned image_w;
   int unsigned image_h;
   int unsigned geometry_count = 0;

   // Sender burst state: a burst of back-to-back pixels, then a random gap.
   int unsigned burst_left = 0;

   function automatic int unsigned clamped(input int unsigned value,
                                           input int unsigned limit);
      if (value == 0)
         return 1;
      return (value > limit) ? limit : value;
   endfunction

   // One APB transfer: setup cycle, then access cycle until pready. The bus
   // idles afterwards so that back-to-back calls never assign psel twice in
   // one time step.
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Offers one pixel and returns at the falling edge after it is taken.
   // The valid line only drops when a real gap follows, so a continuing
   // burst keeps valid high without a glitch.
   task automatic send_pixel(input rgb_type px);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            pixel_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      pixel_ch.valid <= 1'b1;
      pixel_ch.red   <= px.red;
      pixel_ch.green <= px.green;
      pixel_ch.blue  <= px.blue;
      @(posedge clock);
      while (!pixel_ch.ready)
         @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic send_random_pixels(input int unsigned count);
      for (int unsigned i = 0; i < count; i++)
         send_pixel(rgb_type'(24'($urandom())));
   endtask

   // Brings the block to rest: no more pixels offered, every predicted word
   // delivered, then a short pause for a pixel that closed no tile.
   task automatic settle();
      pixel_ch.valid <= 1'b0;
      while (pending_words != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes both size registers at rest and reads them back; the checker
   // compares the readback with its own copy.
   task automatic set_geometry(input logic [CSR_DATA_W-1:0] width_value,
                               input logic [CSR_DATA_W-1:0] height_value);
      settle();
      csr_access(1'b1, WIDTH_ADDR, width_value);
      csr_access(1'b1, HEIGHT_ADDR, height_value);
      csr_access(1'b0, WIDTH_ADDR, '0);
      csr_access(1'b0, HEIGHT_ADDR, '0);
      image_w = clamped(width_value[WIDTH_REG_W-1:0], MAX_WIDTH);
      image_h = clamped(height_value[HEIGHT_REG_W-1:0], HEIGHT_MAX);
      geometry_count++;
   endtask

   // The receiver changes its stall behavior every so often: always ready,
   // mostly ready, mostly stalled, or a fixed on/off rhythm.
   initial begin
      stall_mode_type mode;
      int unsigned    window_left;
      int unsigned    tick;
      word_ch.ready <= 1'b0;
      mode        = STALL_NONE;
      window_left = 0;
      tick        = 0;
      forever begin
         @(negedge clock);
         if (window_left == 0) begin
            mode        = stall_mode_type'($urandom_range(0, 3));
            window_left = $urandom_range(16, 160);
         end
         window_left--;
         tick++;
         case (mode)
            STALL_NONE:  word_ch.ready <= 1'b1;
            STALL_LIGHT: word_ch.ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: word_ch.ready <= ($urandom_range(0, 3) == 0);
            default:     word_ch.ready <= ((tick % 6) < 3);
         endcase
      end
   end

   // Watchdog: any pixel, word or completed register access counts as progress.
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (pixel_ch.valid && pixel_ch.ready) ||
          (word_ch.valid && word_ch.ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("watchdog: no traffic for %0d cycles, %0d words still due",
                  IDLE_LIMIT, pending_words);
         $display("raster_rgb_to_tiled_rgba8_test: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      rgb_type                px;
      int unsigned            random_pixels;
      int unsigned            plan;
      int unsigned            cut;
      int unsigned            new_w;
      int unsigned            count;
      logic [CSR_DATA_W-1:0]  width_value;
      logic [CSR_DATA_W-1:0]  height_value;

      pixel_ch.valid <= 1'b0;
      pixel_ch.red   <= '0;
      pixel_ch.green <= '0;
      pixel_ch.blue  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values must read back as 640 by 480.
      csr_access(1'b0, WIDTH_ADDR, '0);
      csr_access(1'b0, HEIGHT_ADDR, '0);

      // Two pixels into a 640-wide image, then the size drops to one by one
      // while the column count is already past the new last column. The next
      // pixel ends both row and image and flushes a tile of three pixels.
      send_pixel('0);
      send_pixel('1);
      set_geometry(1, 1);
      send_pixel({8'h80, 8'h01, 8'hFE});

      // One full 4x4 tile with zero, all ones, walking bits and checkerboard
      // values, so that each color byte sees both extremes.
      set_geometry(4, 4);
      for (int i = 0; i < 16; i++) begin
         if (i == 0) begin
            px = '0;
         end else if (i == 1) begin
            px = '1;
         end else if (i < 10) begin
            px.red   = 8'h01 << (i - 2);
            px.green = 8'h80 >> (i - 2);
            px.blue  = ~(8'h01 << (i - 2));
         end else begin
            px.red   = (i % 2 == 0) ? 8'hAA : 8'h55;
            px.green = ~px.red;
            px.blue  = (i % 3 == 0) ? 8'hFF : 8'h00;
         end
         send_pixel(px);
      end

      // Zero width and height behave as one: a single pixel makes a tile.
      set_geometry(0, 0);
      send_pixel({8'hFF, 8'h00, 8'h80});

      // A partial tile padded on the right and at the bottom.
      set_geometry(3, 2);
      send_random_pixels(6);

      // Random images of mostly small sizes. Some images are cut short
      // mid-way by lowering the height at a band start or the width within
      // the first row of a band, so the counters end up at or past the new
      // last index. Upper register bits are sometimes filled with noise.
      random_pixels = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         width_value  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 9)
                                                   : $urandom_range(10, 40);
         height_value = $urandom_range(1, 13);
         if (width_value == 1 && $urandom_range(0, 1) == 1)
            width_value = 0;
         if (height_value == 1 && $urandom_range(0, 1) == 1)
            height_value = 0;
         if ($urandom_range(0, 3) == 0) begin
            width_value  = width_value | ($urandom() & 32'hFFFF_F800);
            height_value = height_value | ($urandom() & 32'hFFFF_E000);
         end
         set_geometry(width_value, height_value);

         plan = $urandom_range(0, 5);
         if (plan == 4 && image_h >= 5) begin
            send_random_pixels(4 * image_w);
            settle();
            csr_access(1'b1, HEIGHT_ADDR, $urandom_range(0, 5));
            send_random_pixels(image_w);
            count = 5 * image_w;
         end else if (plan == 5 && image_w >= 2) begin
            cut = $urandom_range(1, image_w - 1);
            send_random_pixels(cut);
            settle();
            new_w = $urandom_range(0, cut + 1);
            csr_access(1'b1, WIDTH_ADDR, new_w);
            count = 1 + (image_h - 1) * clamped(new_w, MAX_WIDTH);
            send_random_pixels(count);
            count = count + cut;
         end else begin
            count = image_w * image_h;
            send_random_pixels(count);
         end
         random_pixels = random_pixels + count;
      end

      // All-ones register values: the width clamps to the line store size and
      // the height to 4096 rows. Each of these images is ended early by a
      // smaller size written at rest, which keeps the run short.
      set_geometry(32'hFFFF_FFFF, 1);
      send_random_pixels(9);
      settle();
      csr_access(1'b1, WIDTH_ADDR, 2);
      send_random_pixels(1);
      set_geometry(1, 32'hFFFF_FFFF);
      send_random_pixels(6);
      settle();
      csr_access(1'b1, HEIGHT_ADDR, 1);
      send_random_pixels(1);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run covered %0d pixels and %0d tile words over %0d size settings,",
               pixels_seen, words_seen, geometry_count);
      $display("including clamped sizes, padded edge tiles and images cut short mid-way");
      if (error_count == 0 && pending_words == 0)
         $display("raster_rgb_to_tiled_rgba8_test: PASS");
      else
         $display("raster_rgb_to_tiled_rgba8_test: FAIL");
      $finish;
   end

endmodule
